// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the wildcard byte pattern scanner.
// Every macro samples on the rising edge of clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression must never be true at a sampled clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/wbps_pkg.sv -----
// Package for the wildcard byte pattern scanner: payload structs,
// register index codes and fixed field widths. No dependencies.
package wbps_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int LEN_W           = 5;
	localparam int ADDR_W          = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WILDCARD_MASK  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS  = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_address;
	} out_t;

endpackage

// ----- hw/rtl/wildcard_byte_pattern_scan_top.sv -----
// Wildcard byte pattern scanner, top level.
// Depends on wbps_pkg and assert_macros.svh.
//
// Scans a byte stream for a pattern of up to MAX_PATTERN bytes with per-position
// wildcards and reports the lowest start address of the first match in each range,
// or a not-found transaction on the last byte of a range without a match. One byte
// is taken per cycle while the result register is not stalled: a transaction is held
// in the input register, and the masked window compare and state update run between
// it and the result register, where the result is registered; the input stalls while
// the result register is stalled. Write configuration only while the block is idle;
// writing start_address also restarts the range.
`include "assert_macros.svh"

module wildcard_byte_pattern_scan_top
	import wbps_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int SEEN_W = $clog2(MAX_PATTERN + 1);

	// configuration
	logic [63:0]       pattern_low_q;
	logic [63:0]       pattern_high_q;
	logic [15:0]       wildcard_mask_q;
	logic [LEN_W-1:0]  pattern_length_q;
	logic [ADDR_W-1:0] start_address_q;

	// scan state
	logic [7:0]        win_q [MAX_PATTERN];
	logic [SEEN_W-1:0] seen_q;
	logic [ADDR_W-1:0] addr_q;
	logic              reported_q;

	// input register
	logic valid_s1;
	in_t  data_s1;

	logic              out_valid_q;
	out_t              out_data_q;

	logic              advance;
	logic              restart_cfg;
	logic [7:0]        win_nxt [MAX_PATTERN];
	logic [LEN_W-1:0]  eff_len;
	logic [SEEN_W-1:0] seen_nxt;
	logic [127:0]      pat_all;
	logic              hit;
	logic              emit;

	assign advance     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall    = valid_s1 && !advance;
	assign restart_cfg = cfg_we && (cfg_index == REG_START_ADDRESS);
	assign pat_all     = {pattern_high_q, pattern_low_q};

	always_comb begin
		win_nxt[0] = data_s1.data_byte;
		for (int i = 1; i < MAX_PATTERN; i++) begin
			win_nxt[i] = win_q[i-1];
		end

		if (pattern_length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (pattern_length_q > LEN_W'(MAX_PATTERN)) begin
			eff_len = LEN_W'(MAX_PATTERN);
		end else begin
			eff_len = pattern_length_q;
		end

		seen_nxt = (seen_q < SEEN_W'(MAX_PATTERN)) ? seen_q + SEEN_W'(1) : seen_q;

		// pattern byte k lines up with window byte len-1-k (newest at 0)
		hit = (LEN_W'(seen_nxt) >= eff_len);
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if ((LEN_W'(k) < eff_len) && !wildcard_mask_q[k] &&
				(win_nxt[IDX_W'(eff_len - LEN_W'(1) - LEN_W'(k))] != pat_all[8*k +: 8])) begin
				hit = 1'b0;
			end
		end

		emit = !reported_q && (hit || data_s1.last_byte);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			wildcard_mask_q  <= '0;
			pattern_length_q <= LEN_W'(1);
			start_address_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				REG_WILDCARD_MASK:  wildcard_mask_q  <= cfg_data[15:0];
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_W-1:0];
				REG_START_ADDRESS:  start_address_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= '0;
			end
			seen_q     <= '0;
			addr_q     <= '0;
			reported_q <= 1'b0;
		end else if (restart_cfg) begin
			seen_q     <= '0;
			addr_q     <= cfg_data;
			reported_q <= 1'b0;
		end else if (advance) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= win_nxt[i];
			end
			if (data_s1.last_byte) begin
				seen_q     <= '0;
				addr_q     <= start_address_q;
				reported_q <= 1'b0;
			end else begin
				seen_q     <= seen_nxt;
				addr_q     <= addr_q + ADDR_W'(1);
				reported_q <= reported_q || hit;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_data_q.found         <= hit;
			out_data_q.match_address <= hit ? addr_q - ADDR_W'(eff_len - LEN_W'(1)) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`ASSERT_CLK(a_notfound_addr_zero, (out_valid && !out_data.found) |-> (out_data.match_address == '0), "not-found transaction with nonzero address")
	`ASSERT_NEVER(a_no_second_result, advance && reported_q && emit, "second result within one range")
	`ASSERT_CLK(a_stall_needs_item, in_stall |-> valid_s1, "input stalled with empty input register")
	`ASSERT_CLK(a_seen_bound, seen_q <= SEEN_W'(MAX_PATTERN), "byte count above window depth")

endmodule

// ----- tb/sv/scan_tracker_pkg.sv -----
// Scoreboard class for the wildcard byte pattern scan testbench: register copies,
// a transaction-level model of the scan and the queue of reports still owed.
// Depends on wbps_pkg.
`timescale 1ns / 1ps

package scan_tracker_pkg;
	import wbps_pkg::*;

	class scan_tracker;
		logic [63:0]      pat_lo;
		logic [63:0]      pat_hi;
		logic [15:0]      wild_mask;
		logic [LEN_W-1:0] len_reg;
		logic [63:0]      start_addr;
		logic [7:0]       window [MAX_PATTERN_DEF];
		int unsigned      seen;
		logic [63:0]      next_addr;
		bit               reported;
		out_t             reports[$];
		int unsigned      mismatches;

		function new();
			pat_lo     = '0;
			pat_hi     = '0;
			wild_mask  = '0;
			len_reg    = LEN_W'(1);
			start_addr = '0;
			mismatches = 0;
			foreach (window[i])
				window[i] = '0;
			restart();
		endfunction

		function void restart();
			seen      = 0;
			reported  = 1'b0;
			next_addr = start_addr;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_PATTERN_LOW: begin
					pat_lo = value;
				end
				REG_PATTERN_HIGH: begin
					pat_hi = value;
				end
				REG_WILDCARD_MASK: begin
					wild_mask = value[15:0];
				end
				REG_PATTERN_LENGTH: begin
					len_reg = value[LEN_W-1:0];
				end
				REG_START_ADDRESS: begin
					start_addr = value;
					restart();
				end
				default: begin
				end
			endcase
		endfunction

		// length in effect: 0 acts as 1, anything past the window acts as full
		function int unsigned span();
			int unsigned n;
			n = 32'(len_reg);
			if (n == 0)
				n = 1;
			if (n > MAX_PATTERN_DEF)
				n = MAX_PATTERN_DEF;
			return n;
		endfunction

		function logic [7:0] pattern_at(int unsigned k);
			if (k < 8)
				return pat_lo[8*k +: 8];
			return pat_hi[8*(k-8) +: 8];
		endfunction

		function bit is_wild(int unsigned k);
			return wild_mask[k];
		endfunction

		function void note_byte(in_t item);
			int unsigned n;
			int unsigned k;
			logic [63:0] addr;
			bit          hit;
			out_t        rpt;
			n    = span();
			addr = next_addr;
			for (k = MAX_PATTERN_DEF - 1; k > 0; k--)
				window[k] = window[k-1];
			window[0] = item.data_byte;
			if (seen < MAX_PATTERN_DEF)
				seen++;
			next_addr = addr + 64'd1;
			if (!reported) begin
				// window[n-1] holds the oldest byte of the candidate
				hit = (seen >= n);
				for (k = 0; k < n; k++)
					if (!wild_mask[k] && window[n-1-k] != pattern_at(k))
						hit = 1'b0;
				if (hit) begin
					reported          = 1'b1;
					rpt.found         = 1'b1;
					rpt.match_address = addr - 64'(n - 1);
					reports = {reports, rpt};
				end else if (item.last_byte) begin
					rpt.found         = 1'b0;
					rpt.match_address = '0;
					reports = {reports, rpt};
				end
			end
			if (item.last_byte)
				restart();
		endfunction

		function void check_report(out_t got);
			out_t want;
			if (reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected report: found=%0b address=%h",
						got.found, got.match_address);
				return;
			end
			want = reports.pop_front();
			if (got.found !== want.found || got.match_address !== want.match_address) begin
				mismatches++;
				if (mismatches <= 10)
					$display("report mismatch: expected found=%0b address=%h, got found=%0b address=%h",
						want.found, want.match_address, got.found, got.match_address);
			end
		endfunction
	endclass

endpackage

// ----- tb/sv/testbench.sv -----
// Top-level testbench for wildcard_byte_pattern_scan_top: drives bytes and register
// writes, stalls the result side at random and checks every report.
// Depends on wbps_pkg, scan_tracker_pkg and the scanner RTL.
`timescale 1ns / 1ps

module testbench;
	import wbps_pkg::*;
	import scan_tracker_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_t                  out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	scan_tracker tracker;
	int unsigned bytes_sent;
	int unsigned cycle_count = 0;
	bit          calm;

	wildcard_byte_pattern_scan_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_report(out_data);
	end

	// result side: stall bursts between free-running stretches
	initial begin
		int unsigned hold;
		bit          stalling;
		out_stall = 1'b0;
		hold      = 0;
		stalling  = 0;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				stalling = !stalling && ($urandom_range(0, 2) == 0);
				hold     = stalling ? $urandom_range(1, 12) : $urandom_range(1, 20);
			end
			hold--;
			out_stall <= stalling && !calm;
		end
	end

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		tracker.write_reg(idx, value);
	endtask

	task automatic send_byte(input logic [7:0] data, input logic last);
		in_t item;
		item.data_byte = data;
		item.last_byte = last;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_stall);
		tracker.note_byte(item);
		bytes_sent++;
		@(negedge clk);
	endtask

	// bytes that give no report may still be in the pipe when the queue empties
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.reports.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	function automatic logic [63:0] pick_word();
		logic [63:0] w;
		int unsigned i;
		case ($urandom_range(0, 5))
			0: w = '0;
			1: w = '1;
			2, 3: w = {$urandom, $urandom};
			default: begin
				// two-letter alphabet makes overlapping candidates likely
				for (i = 0; i < 8; i++)
					w[8*i +: 8] = 8'($urandom_range(8'h41, 8'h42));
			end
		endcase
		return w;
	endfunction

	task automatic random_settings();
		logic [63:0] len;
		logic [63:0] mask;
		logic [63:0] addr;
		if ($urandom_range(0, 1))
			write_cfg(REG_PATTERN_LOW, pick_word());
		if ($urandom_range(0, 2) == 0)
			write_cfg(REG_PATTERN_HIGH, pick_word());
		if ($urandom_range(0, 1)) begin
			case ($urandom_range(0, 5))
				0: mask = '0;
				1: mask = 64'hFFFF;
				2: mask = 64'($urandom_range(0, 16'hFFFF));
				default: mask = 64'(1) << $urandom_range(0, 15);
			endcase
			write_cfg(REG_WILDCARD_MASK, mask);
		end
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 9))
				0: len = '0;
				1: len = 64'(MAX_PATTERN_DEF);
				2: len = 64'($urandom_range(17, 31));
				3: len = 64'($urandom_range(7, 15));
				default: len = 64'($urandom_range(1, 6));
			endcase
			write_cfg(REG_PATTERN_LENGTH, len);
		end
		if ($urandom_range(0, 1)) begin
			case ($urandom_range(0, 3))
				0: addr = '0;
				1: addr = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 20));
				default: addr = {$urandom, $urandom};
			endcase
			write_cfg(REG_START_ADDRESS, addr);
		end
		cfg_we <= 1'b0;
	endtask

	// one range: mostly an embedded pattern instance, some corrupted, some noise
	task automatic scan_range();
		logic [7:0]  bytes_q[$];
		logic [7:0]  b;
		int unsigned n;
		int unsigned k;
		int unsigned kind;
		int unsigned i;
		n    = tracker.span();
		kind = $urandom_range(0, 9);
		repeat ($urandom_range(0, 6)) begin
			if ($urandom_range(0, 1))
				bytes_q = {bytes_q, tracker.pattern_at($urandom_range(0, n - 1))};
			else
				bytes_q = {bytes_q, 8'($urandom)};
		end
		if (kind < 8) begin
			for (k = 0; k < n; k++) begin
				b = tracker.is_wild(k) ? 8'($urandom) : tracker.pattern_at(k);
				bytes_q = {bytes_q, b};
			end
			if (kind == 7) begin
				k = $urandom_range(0, n - 1);
				i = bytes_q.size() - n + k;
				bytes_q[i] = bytes_q[i] ^ (8'h01 << $urandom_range(0, 7));
			end
		end else begin
			repeat ($urandom_range(1, 20))
				bytes_q = {bytes_q, 8'($urandom)};
		end
		repeat ($urandom_range(0, 4))
			bytes_q = {bytes_q, 8'($urandom)};
		// now and then leave the range open across the next settings change
		kind = $urandom_range(0, 7);
		for (i = 0; i < bytes_q.size(); i++)
			send_byte(bytes_q[i], (kind != 0) && (i == bytes_q.size() - 1));
	endtask

	initial begin
		int unsigned i;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		bytes_sent  = 0;
		calm        = 0;
		tracker     = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: one-byte pattern of zero, a range with a match, then one with no match
		send_byte(8'h5A, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b1);
		drain();

		// zero length acts as one; address at the top and wrapping to zero
		write_cfg(REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
		write_cfg(REG_PATTERN_LENGTH, 64'd0);
		write_cfg(REG_START_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF);
		cfg_we <= 1'b0;
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		drain();

		// overlap: "AAB" in "AAAB"; garbage in unused pattern bytes and mask bits
		write_cfg(REG_PATTERN_LOW, 64'hFFFF_FFFF_FF42_4141);
		write_cfg(REG_WILDCARD_MASK, 64'hFFF8);
		write_cfg(REG_PATTERN_LENGTH, 64'd3);
		write_cfg(REG_START_ADDRESS, 64'h1000);
		cfg_we <= 1'b0;
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b1);
		drain();

		// oversize length acts as full window; match lands on the last byte
		write_cfg(REG_PATTERN_HIGH, 64'hC300_0000_0000_0000);
		write_cfg(REG_WILDCARD_MASK, 64'h7FFF);
		write_cfg(REG_PATTERN_LENGTH, 64'd20);
		cfg_we <= 1'b0;
		for (i = 0; i < MAX_PATTERN_DEF; i++)
			send_byte((i == MAX_PATTERN_DEF - 1) ? 8'hC3 : ((i % 2) ? 8'hFF : 8'h00),
				i == MAX_PATTERN_DEF - 1);
		drain();

		while (bytes_sent < 430) begin
			if (bytes_sent >= 360)
				calm = 1;
			random_settings();
			repeat ($urandom_range(1, 6))
				scan_range();
			drain();
		end

		repeat (10) @(negedge clk);
		if (tracker.mismatches == 0 && tracker.reports.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
